@@ hdl/psg_pkg.sv @@
package psg_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned VOL_BITS  = 7;
	localparam int unsigned VOL_MAX   = 100;
	localparam int unsigned GAIN_BITS = WORD_BITS + 1;
	localparam int unsigned PROD_BITS = WORD_BITS + VOL_BITS;

	typedef enum logic [1:0] {
		FMT_S8  = 2'd0,
		FMT_S16 = 2'd1,
		FMT_S24 = 2'd2,
		FMT_S32 = 2'd3
	} sample_format_t;

	localparam logic [1:0] REG_LEFT_VOLUME   = 2'd0;
	localparam logic [1:0] REG_RIGHT_VOLUME  = 2'd1;
	localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd2;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

	localparam logic [VOL_BITS-1:0] LEFT_VOLUME_RESET   = 7'd80;
	localparam logic [VOL_BITS-1:0] RIGHT_VOLUME_RESET  = 7'd80;
	localparam sample_format_t      SAMPLE_FORMAT_RESET = FMT_S16;
	localparam logic [3:0]          CHANNEL_COUNT_RESET = 4'd2;

	// magnitude of the sign-extended sample, its sign, and the gain in percent
	typedef struct packed {
		logic [WORD_BITS-1:0] mag;
		logic                 neg;
		logic [VOL_BITS-1:0]  vol;
	} item_t;

	typedef logic [GAIN_BITS-1:0] gain_tbl_t [2**VOL_BITS];

	// floor(v * 2^32 / 100); the estimate it gives is at most one below the quotient
	function automatic gain_tbl_t build_gain_tbl();
		gain_tbl_t   t;
		logic [63:0] v;
		for (int i = 0; i < 2**VOL_BITS; i++) begin
			v = (i > VOL_MAX) ? 64'(VOL_MAX) : 64'(i);
			t[i] = GAIN_BITS'((v << WORD_BITS) / 64'(VOL_MAX));
		end
		return t;
	endfunction

	localparam gain_tbl_t GAIN_TBL = build_gain_tbl();

endpackage

@@ hdl/psg_front.sv @@
module psg_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [1:0]                           wr_index,
	input  logic [psg_pkg::VOL_BITS-1:0]         wr_data,
	input  logic                                 accept,
	input  logic signed [psg_pkg::WORD_BITS-1:0] sample_word,
	input  logic                                 buffer_start,
	output psg_pkg::item_t                       item
);

	logic [psg_pkg::VOL_BITS-1:0] left_volume_q;
	logic [psg_pkg::VOL_BITS-1:0] right_volume_q;
	psg_pkg::sample_format_t      sample_format_q;
	logic [3:0]                   channel_count_q;
	logic                         channel_phase_q;

	logic [psg_pkg::VOL_BITS-1:0]  lv, rv, vol;
	logic                          phase, phase_d;
	logic [psg_pkg::WORD_BITS-1:0] sx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_volume_q   <= psg_pkg::LEFT_VOLUME_RESET;
			right_volume_q  <= psg_pkg::RIGHT_VOLUME_RESET;
			sample_format_q <= psg_pkg::SAMPLE_FORMAT_RESET;
			channel_count_q <= psg_pkg::CHANNEL_COUNT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				psg_pkg::REG_LEFT_VOLUME:   left_volume_q   <= wr_data;
				psg_pkg::REG_RIGHT_VOLUME:  right_volume_q  <= wr_data;
				psg_pkg::REG_SAMPLE_FORMAT: sample_format_q <= psg_pkg::sample_format_t'(wr_data[1:0]);
				psg_pkg::REG_CHANNEL_COUNT: channel_count_q <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_phase_q <= 1'b0;
		end else if (accept) begin
			channel_phase_q <= phase_d;
		end
	end

	always_comb begin
		lv = (left_volume_q > psg_pkg::VOL_BITS'(psg_pkg::VOL_MAX))
			? psg_pkg::VOL_BITS'(psg_pkg::VOL_MAX) : left_volume_q;
		rv = (right_volume_q > psg_pkg::VOL_BITS'(psg_pkg::VOL_MAX))
			? psg_pkg::VOL_BITS'(psg_pkg::VOL_MAX) : right_volume_q;
		phase = buffer_start ? 1'b0 : channel_phase_q;
		if (channel_count_q > 4'd1) begin
			vol     = phase ? rv : lv;
			phase_d = ~phase;
		end else begin
			// mono takes the louder side
			vol     = (lv > rv) ? lv : rv;
			phase_d = 1'b0;
		end

		case (sample_format_q)
			psg_pkg::FMT_S8:  sx = {{24{sample_word[7]}}, sample_word[7:0]};
			psg_pkg::FMT_S16: sx = {{16{sample_word[15]}}, sample_word[15:0]};
			psg_pkg::FMT_S24: sx = {{8{sample_word[23]}}, sample_word[23:0]};
			default:          sx = sample_word;
		endcase

		item.neg = sx[psg_pkg::WORD_BITS-1];
		item.mag = item.neg ? (~sx + 1'b1) : sx;
		item.vol = vol;
	end

endmodule

@@ hdl/psg_queue.sv @@
module psg_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  psg_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output psg_pkg::item_t pop_item,
	output logic           empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	psg_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/psg_back.sv @@
module psg_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  psg_pkg::item_t                       q_item,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [psg_pkg::WORD_BITS-1:0] scaled_sample
);

	localparam int unsigned PB = psg_pkg::PROD_BITS;
	localparam int unsigned WB = psg_pkg::WORD_BITS;
	localparam int unsigned EB = WB + psg_pkg::GAIN_BITS;

	logic v_s1, v_s2, v_s3;
	logic adv;

	psg_pkg::item_t item_s1;

	logic [WB-1:0] quo_s2;
	logic [PB-1:0] prod_s2;
	logic          neg_s2;

	logic [WB-1:0] res_s3;

	logic [EB-1:0] est;
	logic [PB-1:0] rem;
	logic [WB-1:0] quo;

	// the whole pipe moves when the output slot is free or being taken
	assign adv   = !v_s3 || pop;
	assign q_pop = adv && !q_empty;
	assign empty = !v_s3;
	assign scaled_sample = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		est = EB'(item_s1.mag) * EB'(psg_pkg::GAIN_TBL[item_s1.vol]);
		// the estimate is the quotient or one below it
		rem = prod_s2 - PB'(quo_s2) * PB'(psg_pkg::VOL_MAX);
		quo = quo_s2 + WB'(rem >= PB'(psg_pkg::VOL_MAX));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= q_item;
			quo_s2  <= est[2*WB-1:WB];
			prod_s2 <= PB'(item_s1.mag) * PB'(item_s1.vol);
			neg_s2  <= item_s1.neg;
			res_s3  <= neg_s2 ? (~quo + 1'b1) : quo;
		end
	end

endmodule

@@ hdl/pcm_stereo_software_gain.sv @@
// percent-volume gain stage for a pcm sample stream
//
// input side is a queue: present sample_word and buffer_start with push; the
// request is taken on a clock edge with push high and full low. results come
// out of a queue: while empty is low, scaled_sample holds the oldest result,
// and pop on such an edge takes it. one result per sample, in order.
// configuration: wr_en, wr_index, wr_data write left volume, right volume,
// sample format and channel count; write only while no sample is in flight.
//
// throughput is one sample per clock while pop keeps the output slot free; a
// result left waiting stalls the pipe. an accepted push writes the queue, then
// the sample moves through the operand stage, the 32x33 reciprocal multiply
// stage and the remainder correction and sign restore stage. when pop is held
// low the pipe freezes and the front queue fills; full rises once QUEUE_DEPTH
// samples wait there, so up to QUEUE_DEPTH + 3 samples may be outstanding.
// reset sets both volumes to 80, signed 16 bit, two channels, next sample left,
// and empties the queue and pipe.
module pcm_stereo_software_gain #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [1:0]                           wr_index,
	input  logic [psg_pkg::VOL_BITS-1:0]         wr_data,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [psg_pkg::WORD_BITS-1:0] sample_word,
	input  logic                                 buffer_start,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [psg_pkg::WORD_BITS-1:0] scaled_sample
);

	psg_pkg::item_t front_item, queue_item;
	logic           accept;
	logic           q_pop, q_empty;

	assign accept = push && !full;

	psg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.accept       (accept),
		.sample_word  (sample_word),
		.buffer_start (buffer_start),
		.item         (front_item)
	);

	psg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (full),
		.pop       (q_pop),
		.pop_item  (queue_item),
		.empty     (q_empty)
	);

	psg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_item        (queue_item),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.scaled_sample (scaled_sample)
	);

endmodule

@@ hdl/psg_checker.sv @@
module psg_checker #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 push,
	input logic                                 full,
	input logic                                 empty,
	input logic                                 pop,
	input logic signed [psg_pkg::WORD_BITS-1:0] scaled_sample
);

	localparam int unsigned MAX_OUT = QUEUE_DEPTH + 3;
	localparam int unsigned OW      = $clog2(MAX_OUT + 2);

	logic [OW-1:0] outstanding_q;
	logic          in_acc, out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_acc && !out_acc) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	// a result shows only for a request that is still owed one
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (outstanding_q != '0))
		else $error("result shown with no request outstanding");

	// full only once the queue really holds its depth
	a_full_real: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (outstanding_q >= OW'(QUEUE_DEPTH)))
		else $error("full raised with too few requests outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OW'(MAX_OUT))
		else $error("more requests outstanding than the block can hold");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(scaled_sample)))
		else $error("waiting result changed or vanished");

endmodule

bind pcm_stereo_software_gain psg_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_psg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.push          (push),
	.full          (full),
	.empty         (empty),
	.pop           (pop),
	.scaled_sample (scaled_sample)
);

@@ dv/gain_checker.sv @@
module gain_checker
	import psg_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [1:0]                  wr_index,
	input  logic [VOL_BITS-1:0]         wr_data,
	input  logic                        push,
	input  logic                        full,
	input  logic signed [WORD_BITS-1:0] sample_word,
	input  logic                        buffer_start,
	input  logic                        empty,
	input  logic                        pop,
	input  logic signed [WORD_BITS-1:0] scaled_sample,
	output int unsigned                 mismatches,
	output int unsigned                 outstanding
);

	logic [VOL_BITS-1:0]         left_vol;
	logic [VOL_BITS-1:0]         right_vol;
	sample_format_t              fmt;
	logic [3:0]                  chans;
	logic                        next_right;
	logic signed [WORD_BITS-1:0] expected_samples [$];
	int unsigned                 errs;

	// anything above full scale counts as full scale
	function automatic logic [VOL_BITS-1:0] limit_vol(input logic [VOL_BITS-1:0] v);
		return (v > VOL_BITS'(VOL_MAX)) ? VOL_BITS'(VOL_MAX) : v;
	endfunction

	function automatic logic signed [WORD_BITS-1:0] scale_sample(
		input logic [WORD_BITS-1:0] word,
		input sample_format_t       f,
		input logic [VOL_BITS-1:0]  vol
	);
		longint s;
		longint r;
		case (f)
			FMT_S8:  s = $signed(word[7:0]);
			FMT_S16: s = $signed(word[15:0]);
			FMT_S24: s = $signed(word[23:0]);
			default: s = $signed(word);
		endcase
		// signed division truncates toward zero
		r = (s * longint'(vol)) / longint'(VOL_MAX);
		return r[WORD_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [VOL_BITS-1:0]         lv;
		logic [VOL_BITS-1:0]         rv;
		logic [VOL_BITS-1:0]         vol;
		logic signed [WORD_BITS-1:0] want;
		if (!arst_n) begin
			left_vol = LEFT_VOLUME_RESET;
			right_vol = RIGHT_VOLUME_RESET;
			fmt = SAMPLE_FORMAT_RESET;
			chans = CHANNEL_COUNT_RESET;
			next_right = 1'b0;
			expected_samples.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_LEFT_VOLUME:   left_vol = wr_data;
					REG_RIGHT_VOLUME:  right_vol = wr_data;
					REG_SAMPLE_FORMAT: fmt = sample_format_t'(wr_data[1:0]);
					REG_CHANNEL_COUNT: chans = wr_data[3:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (expected_samples.size() == 0) begin
					$error("scaled_sample: no request waiting, actual %0d", scaled_sample);
					errs++;
				end else begin
					want = expected_samples.pop_front();
					if (scaled_sample !== want) begin
						$error("scaled_sample: expected %0d, actual %0d", want, scaled_sample);
						errs++;
					end
				end
			end
			if (push && !full) begin
				lv = limit_vol(left_vol);
				rv = limit_vol(right_vol);
				if (buffer_start)
					next_right = 1'b0;
				if (chans > 4'd1) begin
					vol = next_right ? rv : lv;
					next_right = ~next_right;
				end else begin
					// mono takes the louder side and parks the phase on left
					vol = (lv > rv) ? lv : rv;
					next_right = 1'b0;
				end
				expected_samples.push_back(scale_sample(sample_word, fmt, vol));
			end
			mismatches <= errs;
			outstanding <= expected_samples.size();
		end
	end

endmodule

@@ dv/tb.sv @@
module tb;
	import psg_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned RAND_PHASES   = 25;
	localparam int unsigned PHASE_SAMPLES = 78;

	logic                        clk;
	logic                        arst_n;
	logic                        wr_en;
	logic [1:0]                  wr_index;
	logic [VOL_BITS-1:0]         wr_data;
	logic                        push;
	logic                        full;
	logic signed [WORD_BITS-1:0] sample_word;
	logic                        buffer_start;
	logic                        empty;
	logic                        pop;
	logic signed [WORD_BITS-1:0] scaled_sample;
	int unsigned                 mismatches;
	int unsigned                 outstanding;

	int unsigned    cycles;
	int unsigned    pop_hold;
	bit             send_calm;
	bit             pop_calm;
	sample_format_t cur_fmt;

	pcm_stereo_software_gain uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.push         (push),
		.full         (full),
		.sample_word  (sample_word),
		.buffer_start (buffer_start),
		.empty        (empty),
		.pop          (pop),
		.scaled_sample(scaled_sample)
	);

	gain_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.push         (push),
		.full         (full),
		.sample_word  (sample_word),
		.buffer_start (buffer_start),
		.empty        (empty),
		.pop          (pop),
		.scaled_sample(scaled_sample),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned next_gap(input bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	always @(posedge clk) begin
		if (pop_hold > 0)
			pop_hold--;
		else
			pop_hold = next_gap(pop_calm);
		pop <= (pop_hold == 0);
	end

	task automatic write_config(
		input logic [VOL_BITS-1:0] lv,
		input logic [VOL_BITS-1:0] rv,
		input sample_format_t      f,
		input logic [3:0]          ch
	);
		wr_en <= 1'b1;
		wr_index <= REG_LEFT_VOLUME;
		wr_data <= lv;
		@(posedge clk);
		wr_index <= REG_RIGHT_VOLUME;
		wr_data <= rv;
		@(posedge clk);
		wr_index <= REG_SAMPLE_FORMAT;
		wr_data <= VOL_BITS'(f);
		@(posedge clk);
		wr_index <= REG_CHANNEL_COUNT;
		wr_data <= VOL_BITS'(ch);
		@(posedge clk);
		wr_en <= 1'b0;
		cur_fmt = f;
	endtask

	task automatic send_sample(input logic [WORD_BITS-1:0] w, input logic s);
		int unsigned gap;
		gap = next_gap(send_calm);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		sample_word <= w;
		buffer_start <= s;
		do @(posedge clk); while (full);
	endtask

	// wait until every request has come back out
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [VOL_BITS-1:0] pick_volume();
		case ($urandom_range(0, 9))
			0:       return 7'd0;
			1:       return 7'd100;
			2:       return 7'($urandom_range(101, 127));
			3:       return 7'd127;
			default: return 7'($urandom_range(0, 100));
		endcase
	endfunction

	function automatic logic [3:0] pick_channels();
		case ($urandom_range(0, 9))
			0:       return 4'd0;
			1:       return 4'd1;
			2, 3:    return 4'd2;
			4:       return 4'd8;
			5:       return 4'd15;
			default: return 4'($urandom_range(0, 15));
		endcase
	endfunction

	// bias the used low bits toward the edges of the format, junk above them
	function automatic logic [WORD_BITS-1:0] pick_word(input sample_format_t f);
		logic [WORD_BITS-1:0] mask;
		logic [WORD_BITS-1:0] lo;
		logic [WORD_BITS-1:0] hi;
		case (f)
			FMT_S8:  mask = 32'h0000_00ff;
			FMT_S16: mask = 32'h0000_ffff;
			FMT_S24: mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
		hi = $urandom;
		case ($urandom_range(0, 9))
			6:       lo = mask >> 1;
			7:       lo = (mask >> 1) ^ mask;
			8:       lo = 32'($urandom_range(0, 6)) - 32'd3;
			9:       lo = $urandom_range(0, 1) ? '1 : '0;
			default: lo = $urandom;
		endcase
		return (hi & ~mask) | (lo & mask);
	endfunction

	initial begin
		int unsigned count;
		int unsigned len;
		bit          noise;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_LEFT_VOLUME;
		wr_data = '0;
		push = 1'b0;
		sample_word = '0;
		buffer_start = 1'b0;
		pop = 1'b0;
		pop_hold = 0;
		cycles = 0;
		send_calm = 1'b0;
		pop_calm = 1'b0;
		cur_fmt = SAMPLE_FORMAT_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 16 bit stereo at 80 percent, buffer starts at the top of a pair
		send_sample(32'h0000_7fff, 1'b1);
		send_sample(32'hffff_8000, 1'b0);
		send_sample(32'h1234_8000, 1'b1);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hffff_ffff, 1'b0);
		send_sample(32'h0000_0001, 1'b0);
		drain();

		// silent left, full right, 8 bit
		write_config(7'd0, 7'd100, FMT_S8, 4'd2);
		send_sample(32'h0000_007f, 1'b1);
		send_sample(32'h0000_0080, 1'b0);
		send_sample(32'habcd_ef80, 1'b0);
		send_sample(32'h0000_00ff, 1'b0);
		drain();

		// volumes over full scale, mono 24 bit with junk in the top byte
		write_config(7'd127, 7'd101, FMT_S24, 4'd1);
		send_sample(32'h007f_ffff, 1'b0);
		send_sample(32'h0080_0000, 1'b0);
		send_sample(32'hff80_0000, 1'b0);
		send_sample(32'hab7f_ffff, 1'b1);
		drain();

		// zero channels is mono too, 32 bit extremes
		write_config(7'd37, 7'd99, FMT_S32, 4'd0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'hffff_ffff, 1'b0);
		drain();

		// back to stereo without a buffer start: mono left the phase on left
		write_config(7'd1, 7'd100, FMT_S32, 4'd15);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			write_config(pick_volume(), pick_volume(), sample_format_t'($urandom_range(0, 3)),
				pick_channels());
			send_calm = ($urandom_range(0, 4) == 0);
			pop_calm = ($urandom_range(0, 4) == 0);
			count = 0;
			while (count < PHASE_SAMPLES) begin
				len = $urandom_range(1, 16);
				noise = ($urandom_range(0, 9) == 0);
				for (int k = 0; k < len && count < PHASE_SAMPLES; k++) begin
					send_sample(pick_word(cur_fmt), noise ? 1'($urandom_range(0, 1)) : (k == 0));
					count++;
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/psg_pkg.sv
hdl/psg_front.sv
hdl/psg_queue.sv
hdl/psg_back.sv
hdl/pcm_stereo_software_gain.sv
hdl/psg_checker.sv
dv/gain_checker.sv
dv/tb.sv
